// ===== design/wbl_pkg.sv =====
// Shared widths, operation codes and item types for the wide bit-vector unit.
package wbl_pkg;

  localparam int unsigned VEC_W    = 128;
  localparam int unsigned HALF_W   = 64;
  localparam int unsigned KIND_W   = 4;
  localparam int unsigned SHIFT_W  = 8;
  localparam int unsigned SH_IDX_W = $clog2(VEC_W);
  localparam int unsigned CNT_W    = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_AND   = 4'd0,
    KIND_OR    = 4'd1,
    KIND_XOR   = 4'd2,
    KIND_NOT   = 4'd3,
    KIND_SHL   = 4'd4,
    KIND_SHR   = 4'd5,
    KIND_POP   = 4'd6,
    KIND_COVER = 4'd7,
    KIND_IDENT = 4'd8,
    KIND_EQ    = 4'd9,
    KIND_NE    = 4'd10,
    KIND_LT    = 4'd11,
    KIND_LE    = 4'd12,
    KIND_GT    = 4'd13,
    KIND_GE    = 4'd14
  } kind_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [HALF_W-1:0]  a_high;
    logic [HALF_W-1:0]  a_low;
    logic [HALF_W-1:0]  b_high;
    logic [HALF_W-1:0]  b_low;
    logic [SHIFT_W-1:0] shift_amount;
  } item_t;

  typedef struct packed {
    logic [HALF_W-1:0] result_high;
    logic [HALF_W-1:0] result_low;
    logic [CNT_W-1:0]  ones_in_a;
    logic              test_flag;
  } result_t;

endpackage

// ===== design/wbl_if.sv =====
// Valid/ready channel interfaces for command and result beats.
interface wbl_cmd_if import wbl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [HALF_W-1:0]  a_high;
  logic [HALF_W-1:0]  a_low;
  logic [HALF_W-1:0]  b_high;
  logic [HALF_W-1:0]  b_low;
  logic [SHIFT_W-1:0] shift_amount;

  modport source (output valid, kind, a_high, a_low, b_high, b_low, shift_amount,
                  input ready);
  modport sink (input valid, kind, a_high, a_low, b_high, b_low, shift_amount,
                output ready);
endinterface

interface wbl_res_if import wbl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] result_high;
  logic [HALF_W-1:0] result_low;
  logic [CNT_W-1:0]  ones_in_a;
  logic              test_flag;

  modport source (output valid, result_high, result_low, ones_in_a, test_flag,
                  input ready);
  modport sink (input valid, result_high, result_low, ones_in_a, test_flag,
                output ready);
endinterface

// ===== design/wbl_core.sv =====
// Combinational datapath: logic ops, shifts, population counts and tests.
module wbl_core import wbl_pkg::*; (
  input  item_t   item,
  output result_t res
);

  // Byte counts, then an adder tree.
  function automatic logic [CNT_W-1:0] ones128(input logic [VEC_W-1:0] v);
    logic [3:0] byte_cnt [16];
    logic [4:0] l1 [8];
    logic [5:0] l2 [4];
    logic [6:0] l3 [2];
    for (int b = 0; b < 16; b++) begin
      byte_cnt[b] = '0;
      for (int i = 0; i < 8; i++) begin
        byte_cnt[b] = byte_cnt[b] + 4'(v[8*b+i]);
      end
    end
    for (int i = 0; i < 8; i++) l1[i] = 5'(byte_cnt[2*i]) + 5'(byte_cnt[2*i+1]);
    for (int i = 0; i < 4; i++) l2[i] = 6'(l1[2*i]) + 6'(l1[2*i+1]);
    for (int i = 0; i < 2; i++) l3[i] = 7'(l2[2*i]) + 7'(l2[2*i+1]);
    return CNT_W'(l3[0]) + CNT_W'(l3[1]);
  endfunction

  logic [VEC_W-1:0]    a_vec;
  logic [VEC_W-1:0]    b_vec;
  logic [VEC_W-1:0]    shl_vec;
  logic [VEC_W-1:0]    shr_vec;
  logic [VEC_W-1:0]    r_vec;
  logic [CNT_W-1:0]    cnt_a;
  logic [CNT_W-1:0]    cnt_b;
  logic [SH_IDX_W-1:0] sh_idx;
  logic                sh_clear;
  logic                flag;

  assign a_vec    = {item.a_high, item.a_low};
  assign b_vec    = {item.b_high, item.b_low};
  assign cnt_a    = ones128(a_vec);
  assign cnt_b    = ones128(b_vec);
  assign sh_idx   = item.shift_amount[SH_IDX_W-1:0];
  // Any distance at or beyond the vector width clears the result.
  assign sh_clear = |item.shift_amount[SHIFT_W-1:SH_IDX_W];
  assign shl_vec  = sh_clear ? '0 : (a_vec << sh_idx);
  assign shr_vec  = sh_clear ? '0 : (a_vec >> sh_idx);

  always_comb begin
    r_vec = '0;
    flag  = 1'b0;
    unique case (kind_t'(item.kind))
      KIND_AND:   r_vec = a_vec & b_vec;
      KIND_OR:    r_vec = a_vec | b_vec;
      KIND_XOR:   r_vec = a_vec ^ b_vec;
      KIND_NOT:   r_vec = ~a_vec;
      KIND_SHL:   r_vec = shl_vec;
      KIND_SHR:   r_vec = shr_vec;
      KIND_POP:   r_vec = '0;
      KIND_COVER: flag  = ((a_vec & b_vec) == b_vec);
      KIND_IDENT: flag  = (a_vec == b_vec);
      KIND_EQ:    flag  = (cnt_a == cnt_b);
      KIND_NE:    flag  = (cnt_a != cnt_b);
      KIND_LT:    flag  = (cnt_a < cnt_b);
      KIND_LE:    flag  = (cnt_a <= cnt_b);
      KIND_GT:    flag  = (cnt_a > cnt_b);
      KIND_GE:    flag  = (cnt_a >= cnt_b);
      default: begin
        r_vec = '0;
        flag  = 1'b0;
      end
    endcase
  end

  assign res.result_high = r_vec[VEC_W-1:HALF_W];
  assign res.result_low  = r_vec[HALF_W-1:0];
  assign res.ones_in_a   = cnt_a;
  assign res.test_flag   = flag;

endmodule

// ===== design/wide_bitvector_logic_unit.sv =====
// An accepted command beat goes to the input register, then the result register.
// One item per cycle while results are taken; input register, datapath, result register.
// While a result waits, the input stage takes a beat only if it is empty.
// Reset clears the two stage valid bits only; payload registers are not reset.
// Top level of the 128-bit bit-vector logic, shift and population count unit.
module wide_bitvector_logic_unit import wbl_pkg::*; (
  input logic       clk,
  input logic       rst,
  wbl_cmd_if.sink   cmd,
  wbl_res_if.source res
);

  logic    s1_valid;
  item_t   s1_item;
  result_t core_res;
  logic    out_valid;
  result_t out_data;
  logic    out_free;
  logic    s1_free;

  assign out_free  = !out_valid || res.ready;
  assign s1_free   = !s1_valid || out_free;
  assign cmd.ready = s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= cmd.valid;
    end
    if (s1_free && cmd.valid) begin
      s1_item <= '{kind: cmd.kind, a_high: cmd.a_high, a_low: cmd.a_low,
                   b_high: cmd.b_high, b_low: cmd.b_low,
                   shift_amount: cmd.shift_amount};
    end
  end

  wbl_core u_core (
    .item (s1_item),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
    if (out_free && s1_valid) begin
      out_data <= core_res;
    end
  end

  assign res.valid       = out_valid;
  assign res.result_high = out_data.result_high;
  assign res.result_low  = out_data.result_low;
  assign res.ones_in_a   = out_data.ones_in_a;
  assign res.test_flag   = out_data.test_flag;

  a_reset_clears: assert property (@(posedge clk) rst |=> !s1_valid && !out_valid)
    else $error("stage valid bits not cleared by reset");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_free |=> out_valid)
    else $error("staged item lost on its way to the result register");

  a_flag_no_vector: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.test_flag |-> out_data.result_high == '0 &&
    out_data.result_low == '0)
    else $error("test flag set alongside a vector result");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.ones_in_a <= CNT_W'(VEC_W))
    else $error("population count out of range");

endmodule
